/* hw/rtl/nbe_pkg.sv */
// ----------------------------------------------------------------------------
// nbe_pkg
// Types and constants shared by the byte escaper front end, queue and back end.
// ----------------------------------------------------------------------------
package nbe_pkg;

  // Printable range, inclusive
  localparam logic [7:0] PRINT_LOW  = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;

  // Escape characters
  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_BSL   = 8'h5C;  // '\'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'

  // Classified byte, as it travels from the front end to the back end
  typedef struct packed {
    logic       pass;      // printable: sent as is
    logic [7:0] ch;        // raw byte
    logic [1:0] hund;      // decimal hundreds digit
    logic [3:0] tens;      // decimal tens digit
    logic [3:0] ones;      // decimal ones digit
    logic       text_end;  // last byte of the text
  } nbe_desc_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } nbe_qstat_t;

endpackage

/* hw/rtl/nbe_front.sv */
// ----------------------------------------------------------------------------
// nbe_front
// Accepts raw bytes, classifies them and splits escaped ones into digits.
// ----------------------------------------------------------------------------
module nbe_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_text_end,
  input  nbe_pkg::nbe_qstat_t q_stat,
  output logic              push,
  output nbe_pkg::nbe_desc_t push_desc
);

  logic               fr_valid_r;
  logic               fr_valid_nxt;
  nbe_pkg::nbe_desc_t fr_desc_r;
  nbe_pkg::nbe_desc_t fr_desc_nxt;
  logic               accept;
  logic [1:0]         hund;
  logic [6:0]         rem100;
  logic [14:0]        tens_prod;
  logic [3:0]         tens;
  logic [6:0]         ones_wide;

  // Held transaction blocks new input only while the queue is full
  assign in_stall = fr_valid_r & q_stat.full;
  assign accept   = in_valid & ~in_stall;
  assign push     = fr_valid_r & ~q_stat.full;
  assign push_desc = fr_desc_r;

  // Decimal split: hundreds by compare, tens by reciprocal multiply
  always_comb begin
    if (in_byte >= 8'd200) begin
      hund = 2'd2;
    end else if (in_byte >= 8'd100) begin
      hund = 2'd1;
    end else begin
      hund = 2'd0;
    end
    rem100    = 7'(in_byte - 8'(hund) * 8'd100);
    tens_prod = 15'(rem100) * 15'd205;   // x/10 == (x*205)>>11 for x < 100
    tens      = tens_prod[14:11];
    ones_wide = rem100 - 7'(tens) * 7'd10;
  end

  always_comb begin
    fr_desc_nxt.pass     = (in_byte >= nbe_pkg::PRINT_LOW) &&
                           (in_byte <= nbe_pkg::PRINT_HIGH);
    fr_desc_nxt.ch       = in_byte;
    fr_desc_nxt.hund     = hund;
    fr_desc_nxt.tens     = tens;
    fr_desc_nxt.ones     = ones_wide[3:0];
    fr_desc_nxt.text_end = in_text_end;
    fr_valid_nxt         = accept | (fr_valid_r & q_stat.full);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    if (accept) begin
      fr_desc_r <= fr_desc_nxt;
    end
  end

  // Checks
  a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> fr_valid_r)
    else $error("stall raised with no held transaction");
  a_held_kept: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid_r && q_stat.full |=> fr_valid_r && $stable(fr_desc_r))
    else $error("held transaction lost while queue full");
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid_r |-> fr_desc_r.tens <= 4'd9 && fr_desc_r.ones <= 4'd9)
    else $error("decimal digit out of range");

endmodule

/* hw/rtl/nbe_queue.sv */
// ----------------------------------------------------------------------------
// nbe_queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module nbe_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nbe_pkg::nbe_desc_t  push_desc,
  input  logic                pop,
  output nbe_pkg::nbe_desc_t  head_desc,
  output nbe_pkg::nbe_qstat_t q_stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nbe_pkg::nbe_desc_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head_desc    = mem[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count past depth");

endmodule

/* hw/rtl/nbe_back.sv */
// ----------------------------------------------------------------------------
// nbe_back
// Walks each queued byte through its character run into the output register.
// ----------------------------------------------------------------------------
module nbe_back (
  input  logic                clk,
  input  logic                rst_n,
  input  nbe_pkg::nbe_desc_t  head_desc,
  input  nbe_pkg::nbe_qstat_t q_stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_char,
  output logic                out_run_last,
  output logic                out_text_end
);

  typedef enum logic [2:0] {
    ST_OPEN,
    ST_BSL,
    ST_HUND,
    ST_TENS,
    ST_ONES,
    ST_CLOSE
  } step_t;

  step_t      state_r;
  step_t      step_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       run_last_r;
  logic       text_end_r;
  logic       head_valid;
  logic       load;
  logic       is_last;
  logic [7:0] ch;

  assign head_valid = ~q_stat.empty;
  assign load       = ~out_valid_r | ~out_stall;
  assign pop        = load & head_valid & is_last;

  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_run_last = run_last_r;
  assign out_text_end = text_end_r;

  // Current character and next step; leading zero digits are skipped
  always_comb begin
    ch       = head_desc.ch;
    is_last  = head_desc.pass;
    step_nxt = ST_OPEN;
    if (!head_desc.pass) begin
      case (state_r)
        ST_OPEN: begin
          ch       = nbe_pkg::CH_OPEN;
          step_nxt = ST_BSL;
        end
        ST_BSL: begin
          ch = nbe_pkg::CH_BSL;
          if (head_desc.hund != 2'd0) begin
            step_nxt = ST_HUND;
          end else if (head_desc.tens != 4'd0) begin
            step_nxt = ST_TENS;
          end else begin
            step_nxt = ST_ONES;
          end
        end
        ST_HUND: begin
          ch       = nbe_pkg::CH_ZERO | 8'(head_desc.hund);
          step_nxt = ST_TENS;
        end
        ST_TENS: begin
          ch       = nbe_pkg::CH_ZERO | 8'(head_desc.tens);
          step_nxt = ST_ONES;
        end
        ST_ONES: begin
          ch       = nbe_pkg::CH_ZERO | 8'(head_desc.ones);
          step_nxt = ST_CLOSE;
        end
        ST_CLOSE: begin
          ch      = nbe_pkg::CH_CLOSE;
          is_last = 1'b1;
        end
        default: begin
          ch      = nbe_pkg::CH_CLOSE;
          is_last = 1'b1;
        end
      endcase
    end
  end

  // Step state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_OPEN;
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        state_r    <= is_last ? ST_OPEN : step_nxt;
        out_char_r <= ch;
        run_last_r <= is_last;
        text_end_r <= is_last & head_desc.text_end;
      end
    end
  end

  // Checks
  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && text_end_r |-> run_last_r)
    else $error("text end flag off the last character of a run");
  a_run_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !run_last_r |=> out_valid_r)
    else $error("gap inside a character run");
  a_mid_run_head: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_OPEN |-> head_valid && !head_desc.pass)
    else $error("mid-run step without an escaped byte at the head");
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && run_last_r && out_char_r != nbe_pkg::CH_CLOSE
      |-> out_char_r >= nbe_pkg::PRINT_LOW && out_char_r <= nbe_pkg::PRINT_HIGH)
    else $error("run ended on a character other than a passed byte or '>'");

endmodule

/* hw/rtl/nonprintable_byte_escaper_unit.sv */
// ----------------------------------------------------------------------------
// nonprintable_byte_escaper_unit
// Byte stream escaper: printable bytes pass, others become "<\ddd>".
//
//   channel   direction  handshake           payload
//   in_       input      in_valid/in_stall   in_byte[7:0], in_text_end
//   out_      output     out_valid/out_stall out_char[7:0], out_run_last,
//                                            out_text_end
//
// One output character per cycle while out_stall is low; a printable byte is
// one character and a three-digit escape six, so the output port sets the rate.
// Input to first character: an accepted input transaction passes the input
// register, the queue and the output register before out_valid rises.
// The queue of QUEUE_DEPTH classified bytes lets input run ahead of output.
// Synchronous active-low reset empties the pipeline; no clearing pass.
// out_stall holds the output register; the queue absorbs input until full.
// ----------------------------------------------------------------------------
module nonprintable_byte_escaper_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_text_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_run_last,
  output logic       out_text_end
);

  nbe_pkg::nbe_qstat_t q_stat;
  nbe_pkg::nbe_desc_t  push_desc;
  nbe_pkg::nbe_desc_t  head_desc;
  logic                push;
  logic                pop;

  // Front end: accept and classify
  nbe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_text_end (in_text_end),
    .q_stat      (q_stat),
    .push        (push),
    .push_desc   (push_desc)
  );

  // Decoupling queue
  nbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .q_stat    (q_stat)
  );

  // Back end: character sequencer
  nbe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_desc    (head_desc),
    .q_stat       (q_stat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for nonprintable_byte_escaper_unit. Directed bytes cover
// the printable edges, zero, one- to three-digit escapes and the high range.
// Random text follows, with bursty input, a patterned output stall and two
// long output hold-offs that back the block up. A predictor builds the
// expected escaped characters, and the monitor checks each output
// transaction in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 250;
  localparam int HOLD_CYCLES = 150;

  // One raw text byte as offered on the input channel
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  // One escaped output character
  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       text_end;
  } esc_char_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte      = 8'd0;
  logic       in_text_end  = 1'b0;
  logic       out_valid;
  logic       out_stall    = 1'b0;
  logic [7:0] out_char;
  logic       out_run_last;
  logic       out_text_end;

  text_byte_t byte_q[$];
  esc_char_t  esc_q[$];

  logic     in_taken    = 1'b0;
  int       n_taken     = 0;
  int       errors      = 0;
  int       cycles      = 0;
  int       burst_left  = 8;
  int       gap_left    = 0;
  int       hold_left   = 0;
  int       holds_done  = 0;
  int       mode_left   = 0;
  rx_mode_t rx_mode     = RX_FREE;

  nonprintable_byte_escaper_unit i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_text_end  (in_text_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_run_last (out_run_last),
    .out_text_end (out_text_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Expected characters for one byte: pass-through or "<\ddd>"
  function automatic void predict_escape(logic [7:0] b, logic last);
    esc_char_t c;
    int        hund;
    int        tens;
    int        ones;
    hund = b / 100;
    tens = (b / 10) % 10;
    ones = b % 10;
    c.run_last = 1'b0;
    c.text_end = 1'b0;
    if (b >= nbe_pkg::PRINT_LOW && b <= nbe_pkg::PRINT_HIGH) begin
      c.ch = b;
    end else begin
      c.ch = nbe_pkg::CH_OPEN;
      esc_q.push_back(c);
      c.ch = nbe_pkg::CH_BSL;
      esc_q.push_back(c);
      if (hund != 0) begin
        c.ch = nbe_pkg::CH_ZERO + 8'(hund);
        esc_q.push_back(c);
      end
      if (hund != 0 || tens != 0) begin
        c.ch = nbe_pkg::CH_ZERO + 8'(tens);
        esc_q.push_back(c);
      end
      c.ch = nbe_pkg::CH_ZERO + 8'(ones);
      esc_q.push_back(c);
      c.ch = nbe_pkg::CH_CLOSE;
    end
    c.run_last = 1'b1;
    c.text_end = last;
    esc_q.push_back(c);
  endfunction

  function automatic void queue_byte(logic [7:0] b, logic last);
    text_byte_t t;
    t.data = b;
    t.last = last;
    byte_q.push_back(t);
  endfunction

  // Driver: bursts of transactions separated by random gaps
  always @(negedge clk) begin
    text_byte_t nxt;
    logic       vld;
    if (rst_n) begin
      vld = in_valid;
      if (in_valid && in_taken) begin
        vld = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (!vld) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() != 0) begin
          nxt = byte_q.pop_front();
          in_byte     <= nxt.data;
          in_text_end <= nxt.last;
          vld = 1'b1;
        end
      end
      // junk on the idle payload must be ignored
      if (!vld && !in_valid) begin
        in_byte     <= 8'($urandom);
        in_text_end <= 1'($urandom);
      end
      in_valid <= vld;
    end
  end

  // Receiver: stall pattern, plus long hold-offs once enough input is in
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && holds_done < 2 &&
          n_taken >= ((holds_done == 0) ? 40 : 160)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 64);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (rx_mode)
          RX_FREE:   out_stall <= 1'b0;
          RX_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
          RX_TOGGLE: out_stall <= ~out_stall;
          default:   out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Monitor: log input transactions into the predictor, check outputs
  always @(posedge clk) begin
    esc_char_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      predict_escape(in_byte, in_text_end);
      n_taken++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (esc_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output char=%02h run_last=%b text_end=%b",
                 $realtime, out_char, out_run_last, out_text_end);
      end else begin
        want = esc_q.pop_front();
        if (out_char !== want.ch) begin
          errors++;
          $display("%0t: out_char expected %02h actual %02h",
                   $realtime, want.ch, out_char);
        end
        if (out_run_last !== want.run_last) begin
          errors++;
          $display("%0t: out_run_last expected %b actual %b",
                   $realtime, want.run_last, out_run_last);
        end
        if (out_text_end !== want.text_end) begin
          errors++;
          $display("%0t: out_text_end expected %b actual %b",
                   $realtime, want.text_end, out_text_end);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL nonprintable_byte_escaper_unit");
      $finish;
    end
  end

  initial begin
    int sel;
    // directed: printable edges, zero, digit-count boundaries, high range
    queue_byte(8'd0,   1'b1);
    queue_byte(8'd32,  1'b0);
    queue_byte(8'd126, 1'b1);
    queue_byte(8'd31,  1'b0);
    queue_byte(8'd127, 1'b0);
    queue_byte(8'd9,   1'b1);
    queue_byte(8'd10,  1'b0);
    queue_byte(8'd99,  1'b0);
    queue_byte(8'd100, 1'b1);
    queue_byte(8'd101, 1'b0);
    queue_byte(8'd199, 1'b0);
    queue_byte(8'd200, 1'b0);
    queue_byte(8'd255, 1'b1);
    queue_byte(8'd128, 1'b0);
    queue_byte(8'd65,  1'b0);
    queue_byte(8'd1,   1'b0);
    queue_byte(8'd170, 1'b0);
    queue_byte(8'd85,  1'b1);
    // random text: mostly printable, with plenty of escapes
    for (int i = 0; i < N_RANDOM; i++) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0, 1: queue_byte(8'($urandom_range(32, 126)), $urandom_range(0, 7) == 0);
        2:    queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        default: begin
          if ($urandom_range(0, 1) == 0)
            queue_byte(8'($urandom_range(0, 31)), $urandom_range(0, 7) == 0);
          else
            queue_byte(8'($urandom_range(127, 255)), $urandom_range(0, 7) == 0);
        end
      endcase
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (esc_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("PASS nonprintable_byte_escaper_unit");
    end else begin
      $display("FAIL nonprintable_byte_escaper_unit");
    end
    $finish;
  end

endmodule
